@@ design/mpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared constants, fixed-point widths and controller/datapath bundles for
// the mandelbrot pixel classifier.
// ----------------------------------------------------------------------------
package mpc_pkg;

  // fixed-point format: sign, three integer bits, FRAC_BITS fraction bits
  localparam int FRAC_BITS = 28;
  localparam int DIM_BITS  = 12;
  localparam int WORD_W    = FRAC_BITS + 4;

  // raster and register widths
  localparam int ROW_W  = DIM_BITS;
  localparam int COL_W  = DIM_BITS + 1;
  localparam int ITER_W = 16;

  // coordinate divider: quotient of 2*num/den with FRAC_BITS fraction bits
  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int QUOT_W    = FRAC_BITS + 2;
  localparam int REM_W     = DIM_BITS + 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // truncated square / product magnitude width
  localparam int SQ_W = 2 * WORD_W - FRAC_BITS;

  // fixed-point constants
  localparam logic signed [WORD_W-1:0] FX_ONE        = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] FX_ONE_HALF3  = FX_ONE + (FX_ONE >>> 1);
  localparam logic signed [WORD_W-1:0] FX_THREE      = WORD_W'(3) << FRAC_BITS;
  localparam logic        [SQ_W:0]     FX_FOUR       = (SQ_W + 1)'(4) << FRAC_BITS;

  // result characters
  localparam logic [7:0] CH_INSIDE  = 8'd35;
  localparam logic [7:0] CH_OUTSIDE = 8'd46;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  // register map indexes
  localparam logic [1:0] REG_IMAGE_ROWS = 2'd0;
  localparam logic [1:0] REG_IMAGE_COLS = 2'd1;
  localparam logic [1:0] REG_ITER_COUNT = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic px_load;      // latch row, start real-part division
    logic div_init_im;  // start imaginary-part division
    logic div_step;     // one divider bit
    logic cr_take;      // quotient into c real
    logic ci_take;      // quotient into c imag
    logic ci_sat;       // c imag saturates at +3
    logic z_clear;      // z to zero
    logic mul;          // register squares and cross product
    logic z_update;     // z = z*z + c
  } mpc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic newline;      // incoming column at or past the width
    logic im_sat;       // row at or past twice the height
    logic sum_gt4;      // |z|^2 above four
    logic sum_ge4;      // |z|^2 at or above four
  } mpc_status_t;

endpackage

@@ design/mpc_datapath.sv @@
// ----------------------------------------------------------------------------
// mpc_datapath
// Bit-serial coordinate divider, c registers and the z*z + c iteration
// unit with three registered multipliers.
// ----------------------------------------------------------------------------
module mpc_datapath (
  input  logic                          clk,
  input  logic [mpc_pkg::ROW_W-1:0]     pixel_row,
  input  logic [mpc_pkg::COL_W-1:0]     pixel_col,
  input  logic [mpc_pkg::COL_W-1:0]     image_rows,
  input  logic [mpc_pkg::COL_W-1:0]     image_cols,
  input  mpc_pkg::mpc_cmd_t             cmd,
  output mpc_pkg::mpc_status_t          status
);

  localparam int W    = mpc_pkg::WORD_W;
  localparam int FB   = mpc_pkg::FRAC_BITS;
  localparam int QW   = mpc_pkg::QUOT_W;
  localparam int RW   = mpc_pkg::REM_W;
  localparam int SW   = mpc_pkg::SQ_W;
  localparam int ROWW = mpc_pkg::ROW_W;
  localparam int COLW = mpc_pkg::COL_W;

  logic [ROWW-1:0]     row_q;
  logic [COLW-1:0]     den;
  logic [RW-1:0]       rem;
  logic [QW-1:0]       quot;
  logic [1:0]          dvd;

  logic signed [W-1:0] cr;
  logic signed [W-1:0] ci;
  logic signed [W-1:0] zr;
  logic signed [W-1:0] zi;

  logic [SW-1:0]       sq_r;
  logic [SW-1:0]       sq_i;
  logic [SW-1:0]       cross_mag;
  logic                cross_neg;

  logic [RW:0]         trial;
  logic [RW:0]         trial_diff;
  logic                trial_fits;

  logic [W-1:0]        abs_zr;
  logic [W-1:0]        abs_zi;
  logic [W-1:0]        two_zr;
  logic [2*W-1:0]      prod_rr;
  logic [2*W-1:0]      prod_ii;
  logic [2*W-1:0]      prod_ri;

  logic [SW:0]         sum_sq;
  logic signed [SW:0]  re_next;
  logic signed [SW:0]  cross_s;
  logic signed [SW:0]  im_next;

  // restoring divider step: shift in the next dividend bit, subtract if it fits
  assign trial      = {rem, dvd[1]};
  assign trial_fits = trial >= (RW + 1)'(den);
  assign trial_diff = trial - (RW + 1)'(den);

  // magnitudes for the truncating products
  assign abs_zr = zr[W-1] ? W'(-zr) : W'(zr);
  assign abs_zi = zi[W-1] ? W'(-zi) : W'(zi);
  // 2*|zr| only matters while |z| has not escaped, where it stays below 4
  assign two_zr = {abs_zr[W-2:0], 1'b0};

  assign prod_rr = abs_zr * abs_zr;
  assign prod_ii = abs_zi * abs_zi;
  assign prod_ri = abs_zi * two_zr;

  // escape test and next z from the registered products
  assign sum_sq  = {1'b0, sq_r} + {1'b0, sq_i};
  assign re_next = $signed({1'b0, sq_r}) - $signed({1'b0, sq_i}) + (SW + 1)'(cr);
  assign cross_s = cross_neg ? -$signed({1'b0, cross_mag}) : $signed({1'b0, cross_mag});
  assign im_next = cross_s + (SW + 1)'(ci);

  // status back to the controller
  assign status.newline = pixel_col >= image_cols;
  // also covers a height of zero
  assign status.im_sat  = {2'b00, row_q, 1'b0} >= {image_rows, 2'b00};
  assign status.sum_gt4 = sum_sq > mpc_pkg::FX_FOUR;
  assign status.sum_ge4 = sum_sq >= mpc_pkg::FX_FOUR;

  // divider registers
  always_ff @(posedge clk) begin
    if (cmd.px_load) begin
      row_q <= pixel_row;
      den   <= image_cols;
      rem   <= RW'(pixel_col >> 1);
      dvd   <= {pixel_col[0], 1'b0};
      quot  <= '0;
    end else if (cmd.div_init_im) begin
      den   <= image_rows;
      rem   <= RW'(row_q >> 1);
      dvd   <= {row_q[0], 1'b0};
      quot  <= '0;
    end else if (cmd.div_step) begin
      rem   <= trial_fits ? RW'(trial_diff) : RW'(trial);
      dvd   <= {dvd[0], 1'b0};
      quot  <= {quot[QW-2:0], trial_fits};
    end
  end

  // c point
  always_ff @(posedge clk) begin
    if (cmd.cr_take) begin
      cr <= $signed(W'(quot)) - mpc_pkg::FX_ONE_HALF3;
    end
    if (cmd.ci_sat) begin
      ci <= mpc_pkg::FX_THREE;
    end else if (cmd.ci_take) begin
      ci <= $signed(W'(quot)) - mpc_pkg::FX_ONE;
    end
  end

  // product registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sq_r      <= prod_rr[2*W-1:FB];
      sq_i      <= prod_ii[2*W-1:FB];
      cross_mag <= prod_ri[2*W-1:FB];
      cross_neg <= zr[W-1] ^ zi[W-1];
    end
  end

  // z registers
  always_ff @(posedge clk) begin
    if (cmd.z_clear) begin
      zr <= '0;
      zi <= '0;
    end else if (cmd.z_update) begin
      zr <= re_next[W-1:0];
      zi <= im_next[W-1:0];
    end
  end

endmodule

@@ design/mpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpc_ctrl
// Sequencer for one pixel: input word, up to two coordinate divisions, the
// iteration loop and the hand-off of the result character.
// ----------------------------------------------------------------------------
module mpc_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mpc_pkg::ITER_W-1:0]        iteration_count,
  input  mpc_pkg::mpc_status_t              status,
  output mpc_pkg::mpc_cmd_t                 cmd,
  input  logic                              out_free,
  output logic                              out_load,
  output logic [7:0]                        out_char
);

  localparam int SW = mpc_pkg::STEP_W;
  localparam int IW = mpc_pkg::ITER_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RE,
    ST_TAKE_RE,
    ST_DIV_IM,
    ST_TAKE_IM,
    ST_MUL,
    ST_CHK,
    ST_OUT
  } state_t;

  state_t        state;
  logic [SW-1:0] step_cnt;
  logic [IW-1:0] iter_cnt;
  logic [7:0]    res_char;

  logic          accept;
  logic          last_step;
  logic          last_iter;

  assign in_ready  = state == ST_IDLE;
  assign accept    = in_valid && in_ready;
  assign last_step = step_cnt == SW'(mpc_pkg::DIV_STEPS - 1);
  assign last_iter = iter_cnt == iteration_count;
  assign out_load  = (state == ST_OUT) && out_free;
  assign out_char  = res_char;

  // command decode
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.px_load = accept && !status.newline;
      end
      ST_DIV_RE, ST_DIV_IM: begin
        cmd.div_step = 1'b1;
      end
      ST_TAKE_RE: begin
        cmd.cr_take     = 1'b1;
        cmd.z_clear     = 1'b1;
        cmd.ci_sat      = status.im_sat;
        cmd.div_init_im = !status.im_sat;
      end
      ST_TAKE_IM: begin
        cmd.ci_take = 1'b1;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_CHK: begin
        cmd.z_update = !last_iter && !status.sum_gt4;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // state, counters and result character
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      iter_cnt <= '0;
      res_char <= mpc_pkg::CH_NEWLINE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (status.newline) begin
              res_char <= mpc_pkg::CH_NEWLINE;
              state    <= ST_OUT;
            end else begin
              step_cnt <= '0;
              state    <= ST_DIV_RE;
            end
          end
        end
        ST_DIV_RE: begin
          step_cnt <= step_cnt + 1'b1;
          if (last_step) begin
            state <= ST_TAKE_RE;
          end
        end
        ST_TAKE_RE: begin
          step_cnt <= '0;
          iter_cnt <= '0;
          state    <= status.im_sat ? ST_MUL : ST_DIV_IM;
        end
        ST_DIV_IM: begin
          step_cnt <= step_cnt + 1'b1;
          if (last_step) begin
            state <= ST_TAKE_IM;
          end
        end
        ST_TAKE_IM: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          // after the last step the bound is inclusive
          if (last_iter) begin
            res_char <= status.sum_ge4 ? mpc_pkg::CH_OUTSIDE : mpc_pkg::CH_INSIDE;
            state    <= ST_OUT;
          end else if (status.sum_gt4) begin
            res_char <= mpc_pkg::CH_OUTSIDE;
            state    <= ST_OUT;
          end else begin
            iter_cnt <= iter_cnt + 1'b1;
            state    <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/mandelbrot_pixel_classifier_top.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_pixel_classifier_top
// Classifies one raster position per input word as inside or outside the
// mandelbrot set, or as end of line, and returns an ascii character.
// ----------------------------------------------------------------------------
// One pixel is worked at a time. A column at or past image_cols skips the
// arithmetic and goes straight to the output state with a newline, after
// which the next word can be taken. Any other pixel runs two coordinate
// divisions on a shared bit-serial divider (FRAC_BITS+2 = 30 quotient bits
// each, the second skipped when the row lies at or past twice the height)
// and then a multiply/update loop of a multiply state and a check state for
// up to iteration_count+1 passes, fewer when z escapes early. The result
// waits in an output register, so the next word is taken as soon as the
// result has been handed to it.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_classifier_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [11:0] pixel_row, [24:12] pixel_col, rest zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_char
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ROWW = mpc_pkg::ROW_W;
  localparam int COLW = mpc_pkg::COL_W;
  localparam int IW   = mpc_pkg::ITER_W;

  logic [COLW-1:0]      image_rows;
  logic [COLW-1:0]      image_cols;
  logic [IW-1:0]        iteration_count;

  logic [ROWW-1:0]      pixel_row;
  logic [COLW-1:0]      pixel_col;

  mpc_pkg::mpc_cmd_t    cmd;
  mpc_pkg::mpc_status_t status;
  logic                 out_free;
  logic                 out_load;
  logic [7:0]           out_char;
  logic                 cfg_write;
  logic [1:0]           reg_index;

  // input word fields
  assign pixel_row = s_tdata[ROWW-1:0];
  assign pixel_col = s_tdata[ROWW+COLW-1:ROWW];

  // register port
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows      <= COLW'(24);
      image_cols      <= COLW'(80);
      iteration_count <= IW'(100);
    end else if (cfg_write) begin
      case (reg_index)
        mpc_pkg::REG_IMAGE_ROWS: image_rows      <= pwdata[COLW-1:0];
        mpc_pkg::REG_IMAGE_COLS: image_cols      <= pwdata[COLW-1:0];
        mpc_pkg::REG_ITER_COUNT: iteration_count <= pwdata[IW-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_index)
      mpc_pkg::REG_IMAGE_ROWS: prdata = 32'(image_rows);
      mpc_pkg::REG_IMAGE_COLS: prdata = 32'(image_cols);
      mpc_pkg::REG_ITER_COUNT: prdata = 32'(iteration_count);
      default:                 prdata = '0;
    endcase
  end

  // output word register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_char;
    end
  end

  // sequencer
  mpc_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .iteration_count (iteration_count),
    .status          (status),
    .cmd             (cmd),
    .out_free        (out_free),
    .out_load        (out_load),
    .out_char        (out_char)
  );

  // arithmetic
  mpc_datapath u_datapath (
    .clk        (clk),
    .pixel_row  (pixel_row),
    .pixel_col  (pixel_col),
    .image_rows (image_rows),
    .image_cols (image_cols),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mandelbrot_pixel_classifier_top. Raster positions
// go in on the input stream, and each returned character is compared with a
// fixed-point predictor kept inside the bench. The run steps through
// register settings that include zero sizes, zero and maximum iteration
// counts and the widest rasters, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD     = 12;
  localparam int          RESET_CYCLES   = 11;
  localparam int          WATCHDOG_LIMIT = 400000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          PRINT_LIMIT    = 20;
  // address with no register behind it
  localparam logic [1:0]  REG_UNUSED     = 2'd3;

  // one raster position as packed into tdata, row in the low bits
  typedef struct packed {
    logic [mpc_pkg::COL_W-1:0] col;
    logic [mpc_pkg::ROW_W-1:0] row;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [11:0] pixel_row, [24:12] pixel_col, rest zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] out_char
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // register copies used by the predictor
  logic [mpc_pkg::COL_W-1:0]  cfg_rows  = 13'd24;
  logic [mpc_pkg::COL_W-1:0]  cfg_cols  = 13'd80;
  logic [mpc_pkg::ITER_W-1:0] cfg_iters = 16'd100;

  pixel_t     pixel_backlog[$];
  logic [7:0] chars_due[$];
  int         words_queued = 0;
  int         words_taken  = 0;
  int         fault_count  = 0;
  int         settings_count = 1;
  int         inside_count = 0;
  int         outside_count = 0;
  int         newline_count = 0;
  int         src_idle_pct = 0;
  int         snk_idle_pct = 0;
  int         src_gap = 0;
  int         snk_gap = 0;
  int         quiet_cycles = 0;

  mandelbrot_pixel_classifier_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // product shifted down by the fraction bits, magnitude truncated
  function automatic longint trunc_mul(input longint a, input longint b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  mag;
    logic [127:0] prod;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    prod = {64'd0, ua} * {64'd0, ub};
    mag = prod[mpc_pkg::FRAC_BITS +: 64];
    mag[63] = 1'b0;
    return ((a < 0) != (b < 0)) ? -$signed(mag) : $signed(mag);
  endfunction

  // floor(2*num/den) in fixed point
  function automatic longint scaled_ratio(input int unsigned num, input int unsigned den);
    logic [63:0] wide;
    wide = 64'(num) * 64'd2;
    wide = (wide << mpc_pkg::FRAC_BITS) / 64'(den);
    return $signed(wide);
  endfunction

  // expected character for one raster position under the current registers
  function automatic logic [7:0] mandel_char(input pixel_t px);
    longint      one;
    longint      cr;
    longint      ci;
    longint      zr;
    longint      zi;
    longint      sr;
    longint      si;
    logic [63:0] mag2;
    logic [63:0] four;
    int unsigned row2;
    int unsigned rows4;
    int unsigned n;
    bit          escaped;
    if (px.col >= cfg_cols) return mpc_pkg::CH_NEWLINE;
    one  = longint'(1) << mpc_pkg::FRAC_BITS;
    four = 64'd4 << mpc_pkg::FRAC_BITS;
    cr = scaled_ratio(px.col, cfg_cols) - (one + one / 2);
    row2  = 2 * int'(px.row);
    rows4 = 4 * int'(cfg_rows);
    // rows at or past twice the height, or no height at all, saturate at +3
    if (cfg_rows == 0 || row2 >= rows4) ci = 3 * one;
    else ci = scaled_ratio(px.row, cfg_rows) - one;
    zr = 0;
    zi = 0;
    escaped = 1'b0;
    for (n = 0; n < cfg_iters; n++) begin
      sr = trunc_mul(zr, zr);
      si = trunc_mul(zi, zi);
      mag2 = sr + si;
      // sticky escape freezes z
      if (mag2 > four) begin
        escaped = 1'b1;
        break;
      end
      zi = trunc_mul(zi, zr * 2) + ci;
      zr = sr - si + cr;
    end
    if (!escaped) begin
      sr = trunc_mul(zr, zr);
      si = trunc_mul(zi, zi);
      mag2 = sr + si;
      escaped = (mag2 >= four);
    end
    return escaped ? mpc_pkg::CH_OUTSIDE : mpc_pkg::CH_INSIDE;
  endfunction

  // --------------------------------------------------------------------------
  // input driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      src_gap = 0;
    end else begin
      // accepted word: work out its character now
      if (s_tvalid && s_tready) begin
        chars_due.push_back(
          mandel_char(pixel_t'(s_tdata[mpc_pkg::COL_W+mpc_pkg::ROW_W-1:0])));
        words_taken++;
      end
      // load the next word once the current one is gone
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
          src_gap = $urandom_range(0, 9);
          s_tvalid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          s_tdata  <= 32'(pixel_backlog.pop_front());
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      m_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (chars_due.size() == 0) begin
          fault_count++;
          if (fault_count <= PRINT_LIMIT)
            $display("%0t: unexpected char, expected none, actual %0d", $time, m_tdata);
        end else begin
          want = chars_due.pop_front();
          if (m_tdata !== want) begin
            fault_count++;
            if (fault_count <= PRINT_LIMIT)
              $display("%0t: out_char mismatch, expected %0d actual %0d",
                       $time, want, m_tdata);
          end
          if (want == mpc_pkg::CH_INSIDE) inside_count++;
          else if (want == mpc_pkg::CH_OUTSIDE) outside_count++;
          else newline_count++;
        end
      end
      // random stall bursts on the result side
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (snk_idle_pct != 0 && $urandom_range(1, 100) <= snk_idle_pct) begin
        snk_gap = $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles with no handshake of any kind
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d words taken, %0d chars due",
               $time, WATCHDOG_LIMIT, words_taken, chars_due.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // register port and stimulus
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [1:0] idx, input logic [31:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      fault_count++;
      if (fault_count <= PRINT_LIMIT)
        $display("%0t: register %0d readback, expected %0d actual %0d",
                 $time, idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    apb_read_check(mpc_pkg::REG_IMAGE_ROWS, 32'(cfg_rows));
    apb_read_check(mpc_pkg::REG_IMAGE_COLS, 32'(cfg_cols));
    apb_read_check(mpc_pkg::REG_ITER_COUNT, 32'(cfg_iters));
  endtask

  // block is idle once every queued word has come back as a char
  task automatic wait_idle();
    while (pixel_backlog.size() != 0 || words_taken != words_queued || chars_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_config(input int unsigned rows, input int unsigned cols,
                            input int unsigned iters);
    wait_idle();
    apb_write(mpc_pkg::REG_IMAGE_ROWS, rows);
    apb_write(mpc_pkg::REG_IMAGE_COLS, cols);
    apb_write(mpc_pkg::REG_ITER_COUNT, iters);
    cfg_rows  = rows[mpc_pkg::COL_W-1:0];
    cfg_cols  = cols[mpc_pkg::COL_W-1:0];
    cfg_iters = iters[mpc_pkg::ITER_W-1:0];
    settings_count++;
    check_regs();
  endtask

  task automatic queue_pixel(input int unsigned row, input int unsigned col);
    pixel_t px;
    px.row = row[mpc_pkg::ROW_W-1:0];
    px.col = col[mpc_pkg::COL_W-1:0];
    pixel_backlog.push_back(px);
    words_queued++;
  endtask

  // mostly positions inside the raster, some end of line, some anything
  task automatic queue_random(input int count);
    int          pick;
    int unsigned row_top;
    row_top = (cfg_rows == 0) ? 0 : ((cfg_rows > 4096) ? 4095 : cfg_rows - 1);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        queue_pixel($urandom_range(0, 4095), cfg_cols);
      else if (pick < 80 && cfg_cols != 0)
        queue_pixel($urandom_range(0, row_top), $urandom_range(0, cfg_cols - 1));
      else
        queue_pixel($urandom_range(0, 4095), $urandom_range(0, 8191));
    end
  endtask

  initial begin
    int count;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, then a few positions under them
    check_regs();
    src_idle_pct = 25;
    snk_idle_pct = 25;
    queue_pixel(0, 0);
    queue_pixel(23, 79);
    queue_pixel(12, 40);
    queue_pixel(12, 60);
    queue_pixel(0, 80);
    queue_pixel(5, 8191);
    queue_pixel(4095, 10);
    queue_pixel(48, 0);
    queue_pixel(47, 0);
    queue_pixel(0, 79);

    // zero iterations; a write to an unmapped address must change nothing
    set_config(4, 4, 0);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    check_regs();
    queue_pixel(0, 0);
    queue_pixel(3, 3);
    queue_pixel(4095, 8191);
    queue_random(20);

    // width zero: every position is end of line
    set_config(0, 0, 7);
    queue_pixel(0, 0);
    queue_pixel(9, 4095);
    queue_random(10);

    // height zero: imaginary part saturates
    set_config(0, 16, 20);
    queue_pixel(0, 0);
    queue_random(15);

    // longest count: the origin never escapes
    set_config(2, 4, 65535);
    queue_pixel(1, 3);
    queue_pixel(0, 0);
    queue_pixel(1, 4);

    // one row and one column at the longest count, all escape early
    set_config(1, 1, 65535);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(2, 0);
    queue_pixel(4095, 0);

    // widest rasters
    set_config(4096, 4096, 1);
    queue_random(40);
    set_config(8191, 8191, 3);
    queue_pixel(4095, 8191);
    queue_random(40);

    // random settings, mostly short counts
    while (words_queued < 740) begin
      if ($urandom_range(0, 4) == 0) begin
        set_config($urandom_range(1, 48), $urandom_range(1, 100), $urandom_range(200, 1000));
        count = 10;
      end else begin
        set_config($urandom_range(1, 48), $urandom_range(1, 100), $urandom_range(0, 120));
        count = 40;
      end
      src_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      snk_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      queue_random(count);
    end

    // closing stretch at full rate
    set_config(24, 80, 100);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    queue_random(60);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d positions over %0d register settings: %0d inside, %0d outside, %0d newline",
             words_taken, settings_count, inside_count, outside_count, newline_count);
    $display("sizes 0 to 8191 and iteration counts 0 to 65535 covered, %0d faults",
             fault_count);
    if (fault_count == 0 && chars_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
